// ===== sv/cpts_pkg.sv =====
// Shared types and codes for the counter/priority task scheduler.
package cpts_pkg;

    // Function codes as they arrive on the input tuser
    localparam logic [2:0] FN_TICK  = 3'd0;
    localparam logic [2:0] FN_LOAD  = 3'd1;
    localparam logic [2:0] FN_PDIS  = 3'd2;
    localparam logic [2:0] FN_PEN   = 3'd3;
    localparam logic [2:0] FN_SCHED = 3'd4;

    // Decoded operation handed from the front to the engine
    typedef enum logic [2:0] {
        OP_TICK,
        OP_LOAD,
        OP_PDIS,
        OP_PEN,
        OP_SCHED,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [5:0] slot;
        logic [7:0] base;
        logic [7:0] extra;
        logic [7:0] slice;
    } t_item;

    // One task table entry as stored in memory
    typedef struct packed {
        logic [7:0] depth;
        logic [7:0] extra;
        logic [7:0] base;
        logic [7:0] cnt;
    } t_entry;

    // Result word, running_task in the lowest bits
    typedef struct packed {
        logic       load_error;
        logic       stalled;
        logic       scheduled;
        logic       switched;
        logic [5:0] running_task;
    } t_result;

endpackage

// ===== sv/counter_priority_task_scheduler_unit.sv =====
// Top level of the counter/priority task scheduler.
// Usage:
//   s_axis carries one command word per beat: tuser holds the function
//   (tick, load, preempt disable/enable, schedule), tdata the load fields.
//   m_axis returns one result word per command: running task and the
//   switched / scheduled / stalled / load_error flags.
//   i_cfg_we / i_cfg_wdata write the selection mode (0 counter only,
//   1 added priority then counter); write only while the block is idle.
// Sequencing:
//   Load and unused codes finish from the idle state; preempt and tick pass
//   through a read-modify-write state. A selection scans entries n-1..1
//   through the single table read port, with a recharge pass and rescan when
//   no count is left. A tick that reschedules first writes its counter update.
//   One command is executed at a time; a two-word queue keeps taking input.
// Reset: table reads as zero, one task (idle) present, task 0 current,
//   counter-only mode. No clearing pass is needed.
// Stall: a waiting result is held on m_axis until taken; the engine starts
//   the next queued command only after its result has left.
module counter_priority_task_scheduler_unit
    import cpts_pkg::*;
#(
    parameter int MAX_TASKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // slot[5:0], base[13:6], extra[21:14], slice[29:22]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // running_task[5:0], switched[6], scheduled[7],
                                        // stalled[8], load_error[9]
);

    logic    r_mode;
    logic    item_vld;
    t_item   item;
    logic    item_pop;
    t_result result;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    cpts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item_vld    (item_vld),
        .o_item        (item),
        .i_item_pop    (item_pop)
    );

    cpts_engine #(
        .MAX_TASKS (MAX_TASKS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_item_vld (item_vld),
        .i_item     (item),
        .o_item_pop (item_pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tdata = {6'd0, result};

endmodule

// ===== sv/cpts_front.sv =====
// Input side: accepts words, decodes the function code, queues decoded items.
module cpts_front
    import cpts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // slot[5:0], base[13:6], extra[21:14], slice[29:22]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        o_item_vld,
    output t_item       o_item,
    input  logic        i_item_pop
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      in_item;
    logic       push;

    // Decode the function code
    always_comb begin
        unique case (s_axis_tuser)
            FN_TICK:  in_item.op = OP_TICK;
            FN_LOAD:  in_item.op = OP_LOAD;
            FN_PDIS:  in_item.op = OP_PDIS;
            FN_PEN:   in_item.op = OP_PEN;
            FN_SCHED: in_item.op = OP_SCHED;
            default:  in_item.op = OP_NOP;
        endcase
        in_item.slot  = s_axis_tdata[5:0];
        in_item.base  = s_axis_tdata[13:6];
        in_item.extra = s_axis_tdata[21:14];
        in_item.slice = s_axis_tdata[29:22];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_item_vld    = (r_cnt != 2'd0);
    assign o_item        = r_q[r_rp];

    // Two-entry queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_item_pop);
        end
    end

endmodule

// ===== sv/cpts_engine.sv =====
// Back side: task table memory, scan/recharge sequencer and result register.
module cpts_engine
    import cpts_pkg::*;
#(
    parameter int MAX_TASKS = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_mode,
    input  logic    i_item_vld,
    input  t_item   i_item,
    output logic    o_item_pop,
    output logic    o_tvalid,
    input  logic    i_tready,
    output t_result o_result
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RMW  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RECH = 3'd3;

    t_entry               mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_vld;
    t_entry               r_rd_data;
    logic                 r_rd_vld;

    logic [2:0]    r_state;
    t_op           r_op;
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_prev;
    logic [CW-1:0] r_tcount;
    logic [AW-1:0] r_idx;
    logic          r_issue;
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    logic          r_have;
    logic [7:0]    r_bcnt;
    logic [7:0]    r_bpri;
    logic [AW-1:0] r_bidx;
    logic          r_recharged;
    logic          r_out_vld;
    t_result       r_out;

    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    t_entry        wd;
    t_entry        ent;
    t_entry        rmw_ent;
    logic          start;
    logic          lerr;
    logic [AW-1:0] last_idx;
    logic [8:0]    rech_sum;
    logic          take;
    logic          tie;
    logic          tick_sched;

    assign ent      = r_rd_vld ? r_rd_data : '0;
    assign start    = (r_state == S_IDLE) && i_item_vld && !r_out_vld;
    assign last_idx = AW'(CW'(r_tcount - CW'(1)));
    assign lerr     = (7'(i_item.slot) > 7'(r_tcount)) ||
                      (7'(i_item.slot) >= 7'(MAX_TASKS));
    assign rech_sum = 9'(ent.cnt >> 1) + 9'(ent.base);

    // Read-modify-write of the current entry
    always_comb begin
        rmw_ent = ent;
        case (r_op)
            OP_TICK: rmw_ent.cnt   = (ent.cnt == 8'd0) ? 8'd0 : ent.cnt - 8'd1;
            OP_PDIS: rmw_ent.depth = (ent.depth == 8'hff) ? 8'hff : ent.depth + 8'd1;
            OP_PEN:  rmw_ent.depth = (ent.depth == 8'd0) ? 8'd0 : ent.depth - 8'd1;
            default: rmw_ent = ent;
        endcase
        tick_sched = i_mode || (rmw_ent.cnt == 8'd0 && rmw_ent.depth == 8'd0);
    end

    // Selection compare for the entry coming out of memory
    always_comb begin
        if (i_mode) begin
            take = (ent.cnt != 8'd0) && (!r_have || ent.extra > r_bpri);
            tie  = r_have && (ent.extra == r_bpri) && (ent.cnt > r_bcnt);
        end else begin
            take = !r_have || (ent.cnt > r_bcnt);
            tie  = 1'b0;
        end
    end

    // Memory port control
    always_comb begin
        rd_addr    = r_idx;
        we         = 1'b0;
        wa         = r_pidx;
        wd         = ent;
        o_item_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = r_cur;
                if (start) begin
                    o_item_pop = 1'b1;
                    if (i_item.op == OP_LOAD && !lerr) begin
                        we = 1'b1;
                        wa = i_item.slot[AW-1:0];
                        wd = '{depth: 8'd0, extra: i_item.extra,
                               base: i_item.base, cnt: i_item.slice};
                    end
                end
            end
            S_RMW: begin
                we = 1'b1;
                wa = r_cur;
                wd = rmw_ent;
            end
            S_SCAN: begin
                rd_addr = r_idx;
            end
            S_RECH: begin
                we     = r_pv;
                wd     = ent;
                wd.cnt = rech_sum[8] ? 8'hff : rech_sum[7:0];
            end
            default: begin
                rd_addr = r_idx;
            end
        endcase
    end

    // Task table storage
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr] || (we && wa == rd_addr);
    end

    // Written-entry marks; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[wa] <= 1'b1;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_tcount    <= CW'(1);
            r_out_vld   <= 1'b0;
            r_issue     <= 1'b0;
            r_pv        <= 1'b0;
            r_have      <= 1'b0;
            r_recharged <= 1'b0;
        end else begin
            if (r_out_vld && i_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op   <= i_item.op;
                        r_prev <= r_cur;
                        case (i_item.op)
                            OP_LOAD: begin
                                if (!lerr && 7'(i_item.slot) == 7'(r_tcount)) begin
                                    r_tcount <= r_tcount + CW'(1);
                                end
                                r_out_vld <= 1'b1;
                                r_out     <= '{load_error: lerr, stalled: 1'b0,
                                               scheduled: 1'b0, switched: 1'b0,
                                               running_task: 6'(r_cur)};
                            end
                            OP_TICK, OP_PDIS, OP_PEN: begin
                                r_state <= S_RMW;
                            end
                            OP_SCHED: begin
                                r_state     <= S_SCAN;
                                r_idx       <= last_idx;
                                r_issue     <= (r_tcount > CW'(1));
                                r_pv        <= 1'b0;
                                r_have      <= 1'b0;
                                r_recharged <= 1'b0;
                            end
                            default: begin
                                r_out_vld <= 1'b1;
                                r_out     <= '{load_error: 1'b0, stalled: 1'b0,
                                               scheduled: 1'b0, switched: 1'b0,
                                               running_task: 6'(r_cur)};
                            end
                        endcase
                    end
                end
                S_RMW: begin
                    if (r_op == OP_TICK && tick_sched) begin
                        r_state     <= S_SCAN;
                        r_idx       <= last_idx;
                        r_issue     <= (r_tcount > CW'(1));
                        r_pv        <= 1'b0;
                        r_have      <= 1'b0;
                        r_recharged <= 1'b0;
                    end else begin
                        r_state   <= S_IDLE;
                        r_out_vld <= 1'b1;
                        r_out     <= '{load_error: 1'b0, stalled: 1'b0,
                                       scheduled: 1'b0, switched: 1'b0,
                                       running_task: 6'(r_cur)};
                    end
                end
                S_SCAN: begin
                    // issue one read a cycle, high index first
                    if (r_issue) begin
                        r_pidx <= r_idx;
                        r_pv   <= 1'b1;
                        if (r_idx == AW'(1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx - AW'(1);
                        end
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (take) begin
                            r_have <= 1'b1;
                            r_bcnt <= ent.cnt;
                            r_bpri <= ent.extra;
                            r_bidx <= r_pidx;
                        end else if (tie) begin
                            r_bcnt <= ent.cnt;
                            r_bidx <= r_pidx;
                        end
                    end
                    if (!r_issue && !r_pv) begin
                        if (r_have && r_bcnt != 8'd0) begin
                            r_state   <= S_IDLE;
                            r_cur     <= r_bidx;
                            r_out_vld <= 1'b1;
                            r_out     <= '{load_error: 1'b0, stalled: 1'b0,
                                           scheduled: 1'b1,
                                           switched: (r_bidx != r_prev),
                                           running_task: 6'(r_bidx)};
                        end else if (!r_recharged) begin
                            r_state <= S_RECH;
                            r_idx   <= '0;
                            r_issue <= 1'b1;
                            r_pv    <= 1'b0;
                        end else begin
                            r_state   <= S_IDLE;
                            r_cur     <= '0;
                            r_out_vld <= 1'b1;
                            r_out     <= '{load_error: 1'b0, stalled: 1'b1,
                                           scheduled: 1'b1,
                                           switched: (r_prev != '0),
                                           running_task: 6'd0};
                        end
                    end
                end
                S_RECH: begin
                    // read entry i, write it back recharged when its data arrives
                    if (r_issue) begin
                        r_pidx <= r_idx;
                        r_pv   <= 1'b1;
                        if (r_idx == last_idx) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (!r_issue && !r_pv) begin
                        r_state     <= S_SCAN;
                        r_idx       <= last_idx;
                        r_issue     <= (r_tcount > CW'(1));
                        r_have      <= 1'b0;
                        r_recharged <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_result = r_out;

endmodule

// ===== sv/cpts_checker.sv =====
// Port-level checks for the scheduler, bound to the top level.
module cpts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A held result word does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // No result right after reset
    a_rst: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

    // A switch or stall only comes from a selection
    a_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[6] || m_axis_tdata[8]) |-> m_axis_tdata[7])
        else $error("switch or stall without selection");

    // A stall always lands on the idle task
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[5:0] == 6'd0)
        else $error("stall with non-idle task");

    // A load error never comes with a selection
    a_lerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> !m_axis_tdata[7])
        else $error("load error with selection");

endmodule

bind counter_priority_task_scheduler_unit cpts_checker u_cpts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/counter_priority_task_scheduler_unit_test.sv =====
// Self-checking testbench for the counter/priority task scheduler top level.
module counter_priority_task_scheduler_unit_test
    import cpts_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = 64;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_WORDS = 80;

    // Predicts the scheduler and checks each result word against it
    class sched_scoreboard;
        logic [7:0] cnt [NUM_SLOTS];
        logic [7:0] base [NUM_SLOTS];
        logic [7:0] extra [NUM_SLOTS];
        logic [7:0] depth [NUM_SLOTS];
        int         ntask;
        logic [5:0] cur;
        bit         by_priority;
        t_result    pending [$];
        int         errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                cnt[i] = 0; base[i] = 0; extra[i] = 0; depth[i] = 0;
            end
            ntask = 1;
            cur = 0;
            by_priority = 0;
            errors = 0;
        endfunction

        // Scan n-1..1, higher index wins ties; -1 when nothing has a count
        function int pick_task();
            int best_cnt, best_pri, chosen;
            best_cnt = -1; best_pri = -1; chosen = -1;
            for (int i = ntask - 1; i > 0; i--) begin
                if (by_priority) begin
                    if (cnt[i] > 0 && int'(extra[i]) > best_pri) begin
                        best_pri = int'(extra[i]); best_cnt = int'(cnt[i]); chosen = i;
                    end else if (int'(cnt[i]) > best_cnt && int'(extra[i]) == best_pri) begin
                        best_cnt = int'(cnt[i]); chosen = i;
                    end
                end else if (int'(cnt[i]) > best_cnt) begin
                    best_cnt = int'(cnt[i]); chosen = i;
                end
            end
            return (best_cnt > 0) ? chosen : -1;
        endfunction

        function void select_task(ref t_result r);
            logic [5:0] prev;
            int chosen, v;
            prev = cur;
            chosen = pick_task();
            if (chosen < 0) begin
                // recharge: half the count plus base, saturating
                for (int i = 0; i < ntask; i++) begin
                    v = int'(cnt[i] >> 1) + int'(base[i]);
                    cnt[i] = (v > 255) ? 8'd255 : v[7:0];
                end
                chosen = pick_task();
            end
            if (chosen < 0) begin
                cur = 0;
                r.stalled = 1'b1;
            end else begin
                cur = chosen[5:0];
            end
            r.switched = (cur != prev);
            r.scheduled = 1'b1;
        endfunction

        // Accepted command word: update the model and queue its result
        function void note_command(logic [2:0] fn, logic [31:0] data);
            t_result r;
            logic [5:0] slot;
            r = '0;
            slot = data[5:0];
            case (fn)
                FN_TICK: begin
                    if (cnt[cur] > 0) cnt[cur]--;
                    if (by_priority || (cnt[cur] == 0 && depth[cur] == 0))
                        select_task(r);
                end
                FN_LOAD: begin
                    if (int'(slot) > ntask) begin
                        r.load_error = 1'b1;
                    end else begin
                        base[slot] = data[13:6];
                        extra[slot] = data[21:14];
                        cnt[slot] = data[29:22];
                        depth[slot] = 0;
                        if (int'(slot) == ntask) ntask++;
                    end
                end
                FN_PDIS: if (depth[cur] < 8'd255) depth[cur]++;
                FN_PEN:  if (depth[cur] > 0) depth[cur]--;
                FN_SCHED: select_task(r);
                default: ;
            endcase
            r.running_task = cur;
            pending.push_back(r);
        endfunction

        function void check_word(logic [15:0] data);
            t_result got, want;
            got = data[9:0];
            if (pending.size() == 0) begin
                $display("%0t: result word with none expected: got %h", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.running_task !== want.running_task)
                $display("%0t: running_task expected %0d actual %0d", $time,
                         want.running_task, got.running_task);
            if (got.switched !== want.switched)
                $display("%0t: switched expected %b actual %b", $time,
                         want.switched, got.switched);
            if (got.scheduled !== want.scheduled)
                $display("%0t: scheduled expected %b actual %b", $time,
                         want.scheduled, got.scheduled);
            if (got.stalled !== want.stalled)
                $display("%0t: stalled expected %b actual %b", $time,
                         want.stalled, got.stalled);
            if (got.load_error !== want.load_error)
                $display("%0t: load_error expected %b actual %b", $time,
                         want.load_error, got.load_error);
            if (data[15:10] !== 6'd0)
                $display("%0t: pad bits expected %h actual %h", $time,
                         6'd0, data[15:10]);
            if (got !== want || data[15:10] !== 6'd0) errors++;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_wdata = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // slot[5:0], base[13:6], extra[21:14], slice[29:22]
    logic [2:0]  s_axis_tuser = '0;   // func[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;        // running_task[5:0], switched[6], scheduled[7],
                                      // stalled[8], load_error[9]

    sched_scoreboard sb = new();
    bit quiet = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    counter_priority_task_scheduler_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Monitors: note accepted commands, check accepted results
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            sb.note_command(s_axis_tuser, s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    // Result side backpressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 19);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] fn, logic [5:0] slot, logic [7:0] bp,
                             logic [7:0] xp, logic [7:0] sl);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {2'b00, sl, xp, bp, slot};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_mode(bit m);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.by_priority = m;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_word();
        logic [5:0] slot;
        logic [31:0] junk;
        int pick;
        pick = $urandom_range(0, 99);
        junk = $urandom;
        if (pick < 30) begin
            send_word(FN_TICK, junk[5:0], junk[13:6], junk[21:14], junk[29:22]);
        end else if (pick < 55) begin
            // mostly legal slots, occasional append, some arbitrary
            if ($urandom_range(0, 9) == 0)
                slot = 6'($urandom_range(0, 63));
            else if (sb.ntask < 63 && (sb.ntask < 6 || $urandom_range(0, 15) == 0))
                slot = 6'(sb.ntask);
            else
                slot = 6'($urandom_range(0, sb.ntask - 1));
            send_word(FN_LOAD, slot, rand_byte(), rand_byte(), rand_byte());
        end else if (pick < 65) begin
            send_word(FN_PDIS, junk[5:0], junk[13:6], junk[21:14], junk[29:22]);
        end else if (pick < 75) begin
            send_word(FN_PEN, junk[5:0], junk[13:6], junk[21:14], junk[29:22]);
        end else if (pick < 95) begin
            send_word(FN_SCHED, junk[5:0], junk[13:6], junk[21:14], junk[29:22]);
        end else begin
            send_word(3'($urandom_range(5, 7)), junk[5:0], junk[13:6], junk[21:14],
                      junk[29:22]);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, load errors, zero priorities, ties, preemption
        send_word(FN_SCHED, 0, 0, 0, 0);
        send_word(FN_TICK, 0, 0, 0, 0);
        send_word(FN_LOAD, 2, 8'd9, 8'd9, 8'd9);
        send_word(FN_LOAD, 1, 0, 0, 0);
        send_word(FN_SCHED, 0, 0, 0, 0);
        send_word(FN_LOAD, 1, 8'd255, 8'd255, 8'd255);
        send_word(FN_LOAD, 2, 8'd3, 8'd255, 8'd255);
        send_word(FN_SCHED, 0, 0, 0, 0);
        send_word(FN_PDIS, 0, 0, 0, 0);
        send_word(FN_TICK, 0, 0, 0, 0);
        send_word(FN_PEN, 0, 0, 0, 0);
        send_word(FN_PEN, 0, 0, 0, 0);
        send_word(FN_LOAD, 2, 8'd0, 8'd0, 8'd1);
        send_word(FN_TICK, 0, 0, 0, 0);
        send_word(3'd5, 6'h3f, 8'hff, 8'hff, 8'hff);
        send_word(3'd6, 0, 0, 0, 0);
        send_word(3'd7, 0, 0, 0, 0);
        send_word(FN_LOAD, 63, 8'hff, 8'hff, 8'hff);
        drain();
        set_mode(1'b1);
        send_word(FN_SCHED, 0, 0, 0, 0);
        send_word(FN_TICK, 0, 0, 0, 0);
        send_word(FN_LOAD, 1, 8'd0, 8'd255, 8'd0);
        send_word(FN_TICK, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_mode(ph[0]);
            if (ph == 3) begin
                quiet = 1;
                // grow the table to its full size once
                while (sb.ntask < NUM_SLOTS)
                    send_word(FN_LOAD, 6'(sb.ntask), rand_byte(), rand_byte(), rand_byte());
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 0 && n == 50) begin
                    // preemption depth saturation at both ends
                    repeat (257) send_word(FN_PDIS, 0, 0, 0, 0);
                    send_word(FN_TICK, 0, 0, 0, 0);
                    repeat (257) send_word(FN_PEN, 0, 0, 0, 0);
                end
                if (ph == 2 && n == 40) drain();
                random_word();
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
